FILE: hdl/bmp_stream_decoder_top_macros.svh
// assertion helpers
`ifndef BMP_STREAM_DECODER_TOP_MACROS_SVH
`define BMP_STREAM_DECODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BMPD_ASSERT_IMPLIES(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("bmpd check failed");
`define BMPD_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("bmpd check failed");
`else
`define BMPD_ASSERT_IMPLIES(lbl, clk, rst, a, c)
`define BMPD_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

FILE: hdl/bmpd_pkg.sv
package bmpd_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 4096;
   localparam int unsigned PAL_AW = 8;
   localparam int unsigned PAL_DW = 24;

   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_MAGIC  = 3'd1;
   localparam logic [2:0] ERR_HDRSZ  = 3'd2;
   localparam logic [2:0] ERR_DEPTH  = 3'd3;
   localparam logic [2:0] ERR_DIM    = 3'd4;
   localparam logic [2:0] ERR_OFFSET = 3'd5;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_SKIP   = 4'b0100,
      PH_PIXELS = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  palette_index;
      logic [11:0] column;
      logic [11:0] image_row;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [2:0]  error_code;
      logic        last_pixel;
   } rsp_type;

endpackage

FILE: hdl/bmpd_channels.sv
interface bmpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       start_of_file;
   modport source (output valid, file_byte, start_of_file, input ready);
   modport sink (input valid, file_byte, start_of_file, output ready);
endinterface

interface bmpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  palette_index;
   logic [11:0] column;
   logic [11:0] image_row;
   logic [12:0] image_width;
   logic [12:0] image_height;
   logic [2:0]  error_code;
   logic        last_pixel;
   modport source (output valid, result_kind, red, green, blue, palette_index, column,
      image_row, image_width, image_height, error_code, last_pixel, input ready);
   modport sink (input valid, result_kind, red, green, blue, palette_index, column,
      image_row, image_width, image_height, error_code, last_pixel, output ready);
endinterface

interface bmpd_csr_if;
   logic valid;
   logic ready;
   logic keep_index;
   modport source (output valid, keep_index, input ready);
   modport sink (input valid, keep_index, output ready);
endinterface

FILE: hdl/bmpd_palette.sv
module bmpd_palette (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [bmpd_pkg::PAL_AW-1:0] wr_addr,
   input  logic [bmpd_pkg::PAL_DW-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [bmpd_pkg::PAL_AW-1:0] rd_addr,
   output logic [bmpd_pkg::PAL_DW-1:0] rd_data
);
   import bmpd_pkg::*;

   logic [PAL_DW-1:0] mem [2**PAL_AW];
   logic [PAL_DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // write-through when the same entry is written in the read cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_ff <= wr_data;
         end else begin
            rd_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: hdl/bmp_stream_decoder_top.sv
// an accepted byte is held in the parse stage register, then its result beat in the output register
// throughput: one file byte per cycle while the output is free, set by the single parse
// stage and the registered palette read issued as the byte is accepted
// reset: synchronous, active high; clears parse state, handshake state and keep_index
// palette contents are not cleared; every entry is written before an 8-bit file reads it
`include "bmp_stream_decoder_top_macros.svh"
module bmp_stream_decoder_top #(
   parameter int unsigned MAX_DIM = bmpd_pkg::MAX_DIM_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bmpd_req_if.sink   req_bus,
   bmpd_rsp_if.source rsp_bus,
   bmpd_csr_if.sink   csr_bus
);
   import bmpd_pkg::*;

   localparam int unsigned DW = $clog2(MAX_DIM + 1);

   phase_type         phase_ff, phase_in;
   logic [31:0]       pos_ff, pos_in;
   logic [31:0]       off_ff, off_in;
   logic              long_ff, long_in;
   logic [DW-1:0]     wid_ff, wid_in;
   logic [DW-1:0]     hgt_ff, hgt_in;
   logic              tdown_ff, tdown_in;
   logic              d24_ff, d24_in;
   logic [31:0]       fld_ff, fld_in;
   logic [DW-1:0]     col_ff, col_in;
   logic [DW-1:0]     frow_ff, frow_in;
   logic [1:0]        bphase_ff, bphase_in;
   logic [1:0]        pad_ff, pad_in;
   logic [15:0]       part_ff, part_in;
   logic [PAL_AW-1:0] pidx_ff, pidx_in;
   logic              keep_ff, keep_in;

   logic              s1_v_ff, s1_v_in;
   logic [7:0]        s1_byte_ff;
   logic              s1_sof_ff;
   logic              o_v_ff, o_v_in;
   rsp_type           o_ff, o_in;

   logic              acc, proc;
   logic              pal_we;
   logic [PAL_DW-1:0] pal_wd, pal_rd;

   logic [31:0]       p_c, g_c, hstart_c, dstart_c, base_c, hend_c, wlen_c, fstart_c;
   logic [31:0]       mag_c;
   logic              neg_c, err_c, res_v;
   logic [7:0]        b_c;
   logic [DW-1:0]     coln_c, rown_c, row_c;
   logic [1:0]        rb_c;
   rsp_type           res;

   function automatic logic [31:0] gather(input logic [31:0] f, input logic [31:0] p,
                                          input logic [31:0] s, input logic [7:0] b);
      logic [31:0] d;
      d = p - s;
      if (d[1:0] == 2'd0) begin
         return {24'd0, b};
      end
      return f | ({24'd0, b} << {d[1:0], 3'b000});
   endfunction

   assign proc          = s1_v_ff && (!o_v_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_v_ff || proc;
   assign acc           = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   bmpd_palette u_palette (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pidx_ff),
      .wr_data (pal_wd),
      .rd_en   (acc),
      .rd_addr (req_bus.file_byte),
      .rd_data (pal_rd)
   );

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      off_in    = off_ff;
      long_in   = long_ff;
      wid_in    = wid_ff;
      hgt_in    = hgt_ff;
      tdown_in  = tdown_ff;
      d24_in    = d24_ff;
      fld_in    = fld_ff;
      col_in    = col_ff;
      frow_in   = frow_ff;
      bphase_in = bphase_ff;
      pad_in    = pad_ff;
      part_in   = part_ff;
      pidx_in   = pidx_ff;
      res_v     = 1'b0;
      res       = '0;
      pal_we    = 1'b0;
      pal_wd    = {s1_byte_ff, part_ff};
      err_c     = 1'b0;
      g_c       = '0;
      mag_c     = '0;
      neg_c     = 1'b0;
      b_c       = s1_byte_ff;
      p_c       = s1_sof_ff ? 32'd0 : pos_ff;
      wlen_c    = long_ff ? 32'd4 : 32'd2;
      hstart_c  = 32'd18 + wlen_c;
      dstart_c  = long_ff ? 32'd28 : 32'd24;
      base_c    = long_ff ? 32'd54 : 32'd26;
      hend_c    = base_c + (d24_ff ? 32'd0 : (long_ff ? 32'd1024 : 32'd768));
      fstart_c  = (p_c < hstart_c) ? 32'd18 : hstart_c;
      coln_c    = col_ff + DW'(1);
      rown_c    = frow_ff + DW'(1);
      row_c     = tdown_ff ? (hgt_ff - DW'(1) - frow_ff) : frow_ff;
      rb_c      = d24_ff ? 2'(wid_ff[1:0] + {wid_ff[0], 1'b0}) : wid_ff[1:0];

      if (proc && (s1_sof_ff || phase_ff != PH_IDLE)) begin
         if (s1_sof_ff) begin
            off_in    = '0;
            long_in   = 1'b0;
            wid_in    = '0;
            hgt_in    = '0;
            tdown_in  = 1'b0;
            d24_in    = 1'b0;
            fld_in    = '0;
            col_in    = '0;
            frow_in   = '0;
            bphase_in = '0;
            pad_in    = '0;
            part_in   = '0;
            pidx_in   = '0;
         end
         pos_in = p_c + 32'd1;
         unique case (s1_sof_ff ? PH_HEADER : phase_ff)
            PH_HEADER: begin
               phase_in = PH_HEADER;
               if (p_c < 32'd2) begin
                  if (p_c == 32'd0) begin
                     fld_in = {24'd0, b_c};
                  end else if (fld_ff != 32'd66 || b_c != 8'd77) begin
                     err_c = 1'b1;
                     res.error_code = ERR_MAGIC;
                  end
               end else if (p_c < 32'd10) begin
                  fld_in = fld_ff;
               end else if (p_c < 32'd14) begin
                  g_c    = gather(fld_ff, p_c, 32'd10, b_c);
                  fld_in = g_c;
                  if (p_c == 32'd13) begin
                     off_in = g_c;
                  end
               end else if (p_c < 32'd18) begin
                  g_c    = gather(fld_ff, p_c, 32'd14, b_c);
                  fld_in = g_c;
                  if (p_c == 32'd17) begin
                     if (g_c == 32'd40) begin
                        long_in = 1'b1;
                     end else if (g_c == 32'd12) begin
                        long_in = 1'b0;
                     end else begin
                        err_c = 1'b1;
                        res.error_code = ERR_HDRSZ;
                     end
                  end
               end else if (p_c < hstart_c + wlen_c) begin
                  g_c    = gather(fld_ff, p_c, fstart_c, b_c);
                  fld_in = g_c;
                  if (p_c == fstart_c + wlen_c - 32'd1) begin
                     if (!long_ff) begin
                        neg_c = g_c[15];
                        mag_c = neg_c ? (32'h10000 - {16'd0, g_c[15:0]}) : {16'd0, g_c[15:0]};
                     end else begin
                        neg_c = g_c[31];
                        mag_c = neg_c ? (32'd0 - g_c) : g_c;
                     end
                     if (fstart_c == 32'd18) begin
                        if (neg_c || mag_c > 32'(MAX_DIM)) begin
                           err_c = 1'b1;
                           res.error_code = ERR_DIM;
                        end else begin
                           wid_in = DW'(mag_c);
                        end
                     end else begin
                        if (mag_c > 32'(MAX_DIM)) begin
                           err_c = 1'b1;
                           res.error_code = ERR_DIM;
                        end else begin
                           tdown_in = neg_c;
                           hgt_in   = DW'(mag_c);
                        end
                     end
                  end
               end else if (p_c >= dstart_c) begin
                  if (p_c < dstart_c + 32'd2) begin
                     g_c    = gather(fld_ff, p_c, dstart_c, b_c);
                     fld_in = g_c;
                     if (p_c == dstart_c + 32'd1) begin
                        if (g_c[15:0] == 16'd24) begin
                           d24_in = 1'b1;
                        end else if (g_c[15:0] == 16'd8) begin
                           d24_in = 1'b0;
                        end else begin
                           err_c = 1'b1;
                           res.error_code = ERR_DEPTH;
                        end
                        hend_c = base_c + (d24_in ? 32'd0 : (long_ff ? 32'd1024 : 32'd768));
                     end
                  end else if (p_c >= base_c && !d24_ff) begin
                     // palette entry assembled blue, green, red; fourth byte dropped
                     case (bphase_ff)
                        2'd0:    part_in[7:0]  = b_c;
                        2'd1:    part_in[15:8] = b_c;
                        2'd2:    pal_we        = 1'b1;
                        default: part_in       = part_ff;
                     endcase
                     if (bphase_ff == (long_ff ? 2'd3 : 2'd2)) begin
                        bphase_in = '0;
                        pidx_in   = pidx_ff + PAL_AW'(1);
                     end else begin
                        bphase_in = bphase_ff + 2'd1;
                     end
                  end
                  if (!err_c && p_c >= dstart_c + 32'd1 && p_c + 32'd1 == hend_c) begin
                     if (off_ff < hend_c) begin
                        err_c = 1'b1;
                        res.error_code = ERR_OFFSET;
                     end else begin
                        res_v = 1'b1;
                        res.result_kind  = KIND_HEADER;
                        res.image_width  = 13'(wid_ff);
                        res.image_height = 13'(hgt_ff);
                        if (wid_ff == '0 || hgt_ff == '0) begin
                           res.last_pixel = 1'b1;
                           phase_in = PH_IDLE;
                        end else if (off_ff == hend_c) begin
                           phase_in = PH_PIXELS;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  end
               end
               if (err_c) begin
                  res_v = 1'b1;
                  res.result_kind = KIND_ERROR;
                  phase_in = PH_IDLE;
               end
            end
            PH_SKIP: begin
               if (p_c + 32'd1 == off_ff) begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (pad_ff != 2'd0) begin
                  pad_in = pad_ff - 2'd1;
               end else begin
                  if (d24_ff) begin
                     if (bphase_ff == 2'd0) begin
                        part_in   = {8'd0, b_c};
                        bphase_in = 2'd1;
                     end else if (bphase_ff == 2'd1) begin
                        part_in[15:8] = b_c;
                        bphase_in     = 2'd2;
                     end else begin
                        bphase_in = 2'd0;
                        res_v     = 1'b1;
                        res.red   = b_c;
                        res.green = part_ff[15:8];
                        res.blue  = part_ff[7:0];
                     end
                  end else begin
                     res_v = 1'b1;
                     res.palette_index = b_c;
                     if (!keep_ff) begin
                        res.blue  = pal_rd[7:0];
                        res.green = pal_rd[15:8];
                        res.red   = pal_rd[23:16];
                     end
                  end
                  if (res_v) begin
                     res.result_kind = KIND_PIXEL;
                     res.column      = 12'(col_ff);
                     res.image_row   = 12'(row_c);
                     col_in = coln_c;
                     if (coln_c >= wid_ff) begin
                        col_in  = '0;
                        frow_in = rown_c;
                        pad_in  = 2'(2'd0 - rb_c);
                        if (rown_c >= hgt_ff) begin
                           res.last_pixel = 1'b1;
                           phase_in = PH_IDLE;
                        end
                     end
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      s1_v_in = acc ? 1'b1 : (proc ? 1'b0 : s1_v_ff);
      o_v_in  = o_v_ff;
      o_in    = o_ff;
      if (proc) begin
         o_v_in = res_v;
         o_in   = res;
      end else if (rsp_bus.ready) begin
         o_v_in = 1'b0;
      end
      keep_in = csr_bus.valid ? csr_bus.keep_index : keep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         off_ff    <= '0;
         long_ff   <= 1'b0;
         wid_ff    <= '0;
         hgt_ff    <= '0;
         tdown_ff  <= 1'b0;
         d24_ff    <= 1'b0;
         fld_ff    <= '0;
         col_ff    <= '0;
         frow_ff   <= '0;
         bphase_ff <= '0;
         pad_ff    <= '0;
         part_ff   <= '0;
         pidx_ff   <= '0;
         keep_ff   <= 1'b0;
         s1_v_ff   <= 1'b0;
         o_v_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         off_ff    <= off_in;
         long_ff   <= long_in;
         wid_ff    <= wid_in;
         hgt_ff    <= hgt_in;
         tdown_ff  <= tdown_in;
         d24_ff    <= d24_in;
         fld_ff    <= fld_in;
         col_ff    <= col_in;
         frow_ff   <= frow_in;
         bphase_ff <= bphase_in;
         pad_ff    <= pad_in;
         part_ff   <= part_in;
         pidx_ff   <= pidx_in;
         keep_ff   <= keep_in;
         s1_v_ff   <= s1_v_in;
         o_v_ff    <= o_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_byte_ff <= req_bus.file_byte;
         s1_sof_ff  <= req_bus.start_of_file;
      end
      o_ff <= o_in;
   end

   assign rsp_bus.valid         = o_v_ff;
   assign rsp_bus.result_kind   = o_ff.result_kind;
   assign rsp_bus.red           = o_ff.red;
   assign rsp_bus.green         = o_ff.green;
   assign rsp_bus.blue          = o_ff.blue;
   assign rsp_bus.palette_index = o_ff.palette_index;
   assign rsp_bus.column        = o_ff.column;
   assign rsp_bus.image_row     = o_ff.image_row;
   assign rsp_bus.image_width   = o_ff.image_width;
   assign rsp_bus.image_height  = o_ff.image_height;
   assign rsp_bus.error_code    = o_ff.error_code;
   assign rsp_bus.last_pixel    = o_ff.last_pixel;

   `BMPD_ASSERT_IMPLIES(a_err_code, clock, reset, o_v_ff && o_ff.result_kind == KIND_ERROR, o_ff.error_code != ERR_NONE)
   `BMPD_ASSERT_IMPLIES(a_pix_clean, clock, reset, o_v_ff && o_ff.result_kind == KIND_PIXEL, o_ff.error_code == ERR_NONE && o_ff.image_width == 13'd0)
   `BMPD_ASSERT_NEXT(a_stage_hold, clock, reset, s1_v_ff && !proc, s1_v_ff)
   `BMPD_ASSERT_IMPLIES(a_ready_free, clock, reset, !s1_v_ff, req_bus.ready)

endmodule

FILE: tb/bmpd_decode_checker.sv
module bmpd_decode_checker (
   input  logic        clock,
   input  logic        reset,
   bmpd_req_if         req_bus,
   bmpd_rsp_if         rsp_bus,
   bmpd_csr_if         csr_bus,
   output int unsigned outstanding,
   output int unsigned fail_count
);
   import bmpd_pkg::*;

   // decoder state mirror
   phase_type   phase;
   bit [31:0]   byte_pos;
   bit [31:0]   data_off;
   bit [31:0]   assembly;
   bit          long_hdr;
   bit          top_down;
   bit          deep;
   bit [31:0]   wid;
   bit [31:0]   hgt;
   bit [31:0]   col_cnt;
   bit [31:0]   row_cnt;
   bit [1:0]    pix_phase;
   bit [1:0]    pad_left;
   bit [15:0]   partial;
   bit [23:0]   palette [256];
   bit          keep_idx;

   rsp_type     expected_q[$];

   assign outstanding = expected_q.size();

   function automatic void clear_parse();
      phase     = PH_IDLE;
      byte_pos  = '0;
      data_off  = '0;
      assembly  = '0;
      long_hdr  = 1'b0;
      top_down  = 1'b0;
      deep      = 1'b0;
      wid       = '0;
      hgt       = '0;
      col_cnt   = '0;
      row_cnt   = '0;
      pix_phase = '0;
      pad_left  = '0;
      partial   = '0;
   endfunction

   function automatic void collect(input bit [31:0] p, input bit [31:0] start,
                                   input bit [7:0] b);
      bit [31:0] k;
      k = (p - start) & 32'd3;
      if (k == 0) assembly = {24'h0, b};
      else assembly = assembly | ({24'h0, b} << (8 * k));
   endfunction

   function automatic bit raise_error(input logic [2:0] code, inout rsp_type r);
      r.result_kind = KIND_ERROR;
      r.error_code  = code;
      phase = PH_IDLE;
      return 1'b1;
   endfunction

   function automatic bit header_step(input bit [31:0] p, input bit [7:0] b,
                                      inout rsp_type r);
      bit [31:0] wlen, hstart, dstart, base, hdr_end, start, v, mag, off, idx, sub;
      bit        neg;
      if (p < 2) begin
         if (p == 0) assembly = {24'h0, b};
         else if (assembly != 32'd66 || b != 8'd77) return raise_error(ERR_MAGIC, r);
         return 1'b0;
      end
      if (p < 10) return 1'b0;
      if (p < 14) begin
         collect(p, 10, b);
         if (p == 13) data_off = assembly;
         return 1'b0;
      end
      if (p < 18) begin
         collect(p, 14, b);
         if (p == 17) begin
            if (assembly == 32'd40) long_hdr = 1'b1;
            else if (assembly == 32'd12) long_hdr = 1'b0;
            else return raise_error(ERR_HDRSZ, r);
         end
         return 1'b0;
      end
      wlen   = long_hdr ? 32'd4 : 32'd2;
      hstart = 32'd18 + wlen;
      dstart = long_hdr ? 32'd28 : 32'd24;
      base   = long_hdr ? 32'd54 : 32'd26;
      if (p < hstart + wlen) begin
         start = (p < hstart) ? 32'd18 : hstart;
         collect(p, start, b);
         if (p == start + wlen - 1) begin
            v = assembly;
            if (wlen == 2) begin
               v   = v & 32'hFFFF;
               neg = v[15];
               mag = neg ? (32'h10000 - v) : v;
            end else begin
               neg = v[31];
               mag = neg ? (32'd0 - v) : v;
            end
            if (start == 18) begin
               if (neg || mag > 32'd4096) return raise_error(ERR_DIM, r);
               wid = mag;
            end else begin
               if (mag > 32'd4096) return raise_error(ERR_DIM, r);
               top_down = neg;
               hgt = mag;
            end
         end
         return 1'b0;
      end
      if (p < dstart) return 1'b0;
      if (p < dstart + 2) begin
         collect(p, dstart, b);
         if (p == dstart + 1) begin
            if (assembly[15:0] == 16'd24) deep = 1'b1;
            else if (assembly[15:0] == 16'd8) deep = 1'b0;
            else return raise_error(ERR_DEPTH, r);
         end
      end else if (p >= base && !deep) begin
         off = p - base;
         if (long_hdr) begin
            idx = off >> 2;
            sub = off & 32'd3;
         end else begin
            idx = off / 3;
            sub = off % 3;
         end
         if (sub < 3) palette[idx[7:0]][8 * sub +: 8] = b;
      end
      hdr_end = base + (deep ? 32'd0 : (long_hdr ? 32'd1024 : 32'd768));
      if (p >= dstart + 1 && p + 1 == hdr_end) begin
         if (data_off < hdr_end) return raise_error(ERR_OFFSET, r);
         r.result_kind  = KIND_HEADER;
         r.image_width  = wid[12:0];
         r.image_height = hgt[12:0];
         if (wid == 0 || hgt == 0) begin
            r.last_pixel = 1'b1;
            phase = PH_IDLE;
         end else begin
            phase = (data_off == hdr_end) ? PH_PIXELS : PH_SKIP;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit pixel_step(input bit [7:0] b, inout rsp_type r);
      bit [31:0] row, rb;
      bit [23:0] entry;
      if (pad_left != 0) begin
         pad_left = pad_left - 2'd1;
         return 1'b0;
      end
      if (deep) begin
         if (pix_phase == 0) begin
            partial   = {8'h0, b};
            pix_phase = 2'd1;
            return 1'b0;
         end
         if (pix_phase == 1) begin
            partial[15:8] = b;
            pix_phase     = 2'd2;
            return 1'b0;
         end
         pix_phase = 2'd0;
         r.red   = b;
         r.green = partial[15:8];
         r.blue  = partial[7:0];
      end else begin
         r.palette_index = b;
         if (!keep_idx) begin
            entry   = palette[b];
            r.blue  = entry[7:0];
            r.green = entry[15:8];
            r.red   = entry[23:16];
         end
      end
      row = top_down ? (hgt - 32'd1 - row_cnt) : row_cnt;
      r.result_kind = KIND_PIXEL;
      r.column      = col_cnt[11:0];
      r.image_row   = row[11:0];
      col_cnt = col_cnt + 1;
      if (col_cnt >= wid) begin
         rb       = wid * (deep ? 32'd3 : 32'd1);
         col_cnt  = '0;
         row_cnt  = row_cnt + 1;
         pad_left = 2'(2'd0 - rb[1:0]);
         if (row_cnt >= hgt) begin
            r.last_pixel = 1'b1;
            phase = PH_IDLE;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit decode_byte(input bit [7:0] b, input bit sof,
                                      output rsp_type r);
      bit [31:0] p;
      r = '0;
      if (sof) begin
         clear_parse();
         phase = PH_HEADER;
      end else if (phase == PH_IDLE) begin
         return 1'b0;
      end
      p = byte_pos;
      byte_pos = p + 1;
      case (phase)
         PH_HEADER: return header_step(p, b, r);
         PH_SKIP: begin
            if (byte_pos == data_off) phase = PH_PIXELS;
            return 1'b0;
         end
         PH_PIXELS: return pixel_step(b, r);
         default: begin
            phase = PH_IDLE;
            return 1'b0;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want, got, pred;
      if (reset) begin
         clear_parse();
         keep_idx = 1'b0;
         expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.result_kind, rsp_bus.red, rsp_bus.green, rsp_bus.blue,
                    rsp_bus.palette_index, rsp_bus.column, rsp_bus.image_row,
                    rsp_bus.image_width, rsp_bus.image_height, rsp_bus.error_code,
                    rsp_bus.last_pixel};
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) keep_idx = csr_bus.keep_index;
         if (req_bus.valid && req_bus.ready)
            if (decode_byte(req_bus.file_byte, req_bus.start_of_file, pred))
               expected_q.push_back(pred);
      end
   end

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import bmpd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned ITEM_TARGET = 1350;

   logic clock;
   logic reset;
   int unsigned outstanding;
   int unsigned fail_count;
   int unsigned cycle_count = 0;
   int unsigned items;
   bit          no_idle;
   bit [7:0]    file_q[$];

   bmpd_req_if req_bus();
   bmpd_rsp_if rsp_bus();
   bmpd_csr_if csr_bus();

   bmp_stream_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bmpd_decode_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      int unsigned w;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = no_idle ? 0 : $urandom_range(0, 12);
         if (w != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         @(negedge clock);
      end
   end

   task automatic send_beat(input bit [7:0] b, input bit sof);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.file_byte     <= b;
      req_bus.start_of_file <= sof;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_keep(input bit value);
      drain();
      csr_bus.valid      <= 1'b1;
      csr_bus.keep_index <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic push_le(input bit [31:0] value, input int n);
      for (int i = 0; i < n; i++) file_q.push_back(value[8 * i +: 8]);
   endtask

   // lays out one file in file_q; extra is added to the real end of the header
   task automatic build_file(input bit [31:0] hsize, input int w, input int h,
                             input bit [15:0] depth, input int extra, input bit with_pix);
      bit          is_long;
      int          hdr_end, bpp, rows, row_bytes;
      file_q.delete();
      is_long = (hsize == 32'd40);
      hdr_end = (is_long ? 54 : 26) + (depth == 16'd8 ? (is_long ? 1024 : 768) : 0);
      file_q.push_back(8'd66);
      file_q.push_back(8'd77);
      repeat (8) file_q.push_back(8'($urandom));
      push_le(hdr_end + extra, 4);
      push_le(hsize, 4);
      if (hsize != 32'd40 && hsize != 32'd12) begin
         repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
         return;
      end
      push_le(w, is_long ? 4 : 2);
      push_le(h, is_long ? 4 : 2);
      push_le($urandom, 2);
      push_le({16'h0, depth}, 2);
      if (is_long) repeat (24) file_q.push_back(8'($urandom));
      if (depth == 16'd8) repeat (256 * (is_long ? 4 : 3)) file_q.push_back(8'($urandom));
      if (!with_pix) return;
      repeat (extra) file_q.push_back(8'($urandom));
      bpp = (depth == 16'd24) ? 3 : 1;
      rows = (h < 0) ? -h : h;
      row_bytes = w * bpp;
      for (int r = 0; r < rows; r++) begin
         repeat (row_bytes) file_q.push_back(8'($urandom));
         repeat ((4 - (row_bytes % 4)) % 4) file_q.push_back(8'($urandom));
      end
      repeat ($urandom_range(0, 2)) file_q.push_back(8'($urandom));
   endtask

   task automatic send_file(input int upto);
      for (int i = 0; i < file_q.size() && i < upto; i++) begin
         send_beat(file_q[i], i == 0);
         items++;
      end
   endtask

   task automatic send_rest(input int from);
      for (int i = from; i < file_q.size(); i++) begin
         send_beat(file_q[i], i == 0);
         items++;
      end
   endtask

   task automatic random_good(input bit [15:0] depth);
      int w, h;
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) h = -h;
      build_file($urandom_range(0, 1) ? 32'd40 : 32'd12, w, h, depth,
                 $urandom_range(0, 3), 1'b1);
   endtask

   task automatic random_broken();
      case ($urandom_range(0, 7))
         0: begin
            build_file(32'd12, 1, 1, 16'd24, 0, 1'b0);
            file_q[$urandom_range(0, 1)] = 8'($urandom);
         end
         1: build_file($urandom, 1, 1, 16'd24, 0, 1'b0);
         2: build_file(32'd40, 2, 2, 16'($urandom), 0, 1'b0);
         3: build_file(32'd40, -$urandom_range(1, 5000), 1, 16'd24, 0, 1'b0);
         4: build_file(32'd12, 1, $urandom_range(0, 1) ? 4097 : -4097, 16'd24, 0, 1'b0);
         5: build_file(32'd40, 1, 1, 16'd24, -$urandom_range(1, 54), 1'b0);
         6: build_file(32'd12, $urandom_range(0, 1) ? 0 : 4096, 0, 16'd24, 0, 1'b0);
         default: build_file(32'd40, $urandom_range(0, 4096), 0, 16'd24, 0, 1'b0);
      endcase
   endtask

   initial begin
      int unsigned sel;
      reset = 1'b1;
      no_idle = 1'b0;
      items = 0;
      req_bus.valid = 1'b0;
      req_bus.file_byte = '0;
      req_bus.start_of_file = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.keep_index = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_keep(1'b0);
      // directed: bytes while idle, every error kind, the dimension extremes, then small valid files
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      build_file(32'd12, 1, 1, 16'd24, 0, 1'b0); file_q[0] = 8'd88; send_file(2);
      build_file(32'd12, 1, 1, 16'd24, 0, 1'b0); file_q[1] = 8'd0;  send_file(2);
      build_file(32'd41, 1, 1, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'hFFFF_FFFF, 1, 1, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd40, 1, 1, 16'd16, 0, 1'b0); send_file(99);
      build_file(32'd40, 4097, 1, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd40, -1, 1, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd12, 1, -4097, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd12, 4096, 0, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd40, 0, -4096, 16'd24, 0, 1'b0); send_file(99);
      build_file(32'd40, 1, 1, 16'd24, -1, 1'b0); send_file(99);
      build_file(32'd12, 1, 1, 16'd24, 0, 1'b1); send_file(99);
      build_file(32'd40, 3, -2, 16'd24, 2, 1'b1); send_file(99);
      build_file(32'd12, 2, 2, 16'd24, 1, 1'b1); send_file(99);
      drain();
      // 8-bit file: first row through the palette, second row as raw index
      build_file(32'd12, 5, 2, 16'd8, 0, 1'b1); send_file(802);
      write_keep(1'b1);
      send_rest(802);
      write_keep(1'b0);
      drain();

      while (items < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            random_good(16'd24);
            send_file(99999);
         end else if (sel < 62 && items + 1200 <= ITEM_TARGET) begin
            random_good(16'd8);
            send_file(99999);
         end else if (sel < 80) begin
            random_broken();
            send_file(99999);
         end else if (sel < 90) begin
            random_good(16'd24);
            send_file($urandom_range(1, file_q.size()));
         end else begin
            repeat ($urandom_range(1, 5)) begin
               send_beat(8'($urandom), 1'b0);
               items++;
            end
         end
         if ($urandom_range(0, 19) == 0) no_idle = ~no_idle;
         if ($urandom_range(0, 24) == 0) write_keep($urandom_range(0, 1));
      end

      drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bmpd_pkg.sv
hdl/bmpd_channels.sv
hdl/bmpd_palette.sv
hdl/bmp_stream_decoder_top.sv
tb/bmpd_decode_checker.sv
tb/tb_top.sv
